// ===== rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, tables and types of the differential drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 24;

  localparam int RADIUS_W = 20;
  localparam int GAIN_W   = 36;
  localparam int DT_W     = 24;
  localparam int CORDIC_W = 30;
  localparam int Z_W      = 34;
  localparam int MD_N_W   = 7;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 20'd11469;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 36'd854456594;

  localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 30'd40752055;
  localparam logic [63:0]         MICROS      = 64'd1000000;
  localparam logic [63:0]         YAW_K       = 64'd3373259426000000;
  localparam int                  MICROS_W    = 20;
  localparam int                  YAW_K_W     = 52;

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic              start;
    md_op_e            op;
    logic [MD_N_W-1:0] nbits;
  } md_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIF,
    S_TH,
    S_X,
    S_Y,
    S_LIN,
    S_LDIV,
    S_YAW,
    S_YDIV,
    S_DONE
  } state_e;

endpackage

// ===== rtl/ddo_muldiv.sv =====
// ----------------------------------------------------------------------------
// ddo_muldiv
// Shared serial unit: shift-add multiply or restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module ddo_muldiv import ddo_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  md_req_t       req_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  output logic          done_o,
  output logic [127:0]  acc_o
);

  logic [127:0]      acc_q, acc_d;
  logic [63:0]       bsh_q, bsh_d;
  logic [63:0]       den_q;
  md_op_e            op_q;
  logic [MD_N_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [63:0]       rem_t;
  logic              qbit;

  always_comb begin
    rem_t  = acc_q[126:63];
    qbit   = 1'b0;
    bsh_d  = bsh_q;
    unique case (op_q)
      MD_MUL: begin
        acc_d = {acc_q[126:0], 1'b0} + (bsh_q[63] ? {64'd0, a_i} : 128'd0);
        bsh_d = {bsh_q[62:0], 1'b0};
      end
      MD_DIV: begin
        if (rem_t >= den_q) begin
          rem_t = rem_t - den_q;
          qbit  = 1'b1;
        end
        acc_d = {rem_t, acc_q[62:0], qbit};
      end
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MD_MUL;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      op_q   <= req_i.op;
      cnt_q  <= (req_i.op == MD_MUL) ? req_i.nbits : MD_N_W'(64);
    end else if (busy_q) begin
      cnt_q <= cnt_q - MD_N_W'(1);
      if (cnt_q == MD_N_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= b_i;
      if (req_i.op == MD_MUL) begin
        acc_q <= '0;
        bsh_q <= b_i << (MD_N_W'(64) - req_i.nbits);
      end else begin
        acc_q <= {64'd0, a_i};
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      bsh_q <= bsh_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

// ===== rtl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation CORDIC: cosine and sine of a binary angle, Q26.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [31:0]                angle_i,
  output logic                       done_o,
  output logic signed [CORDIC_W-1:0] cos_o,
  output logic signed [CORDIC_W-1:0] sin_o
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic signed [CORDIC_W-1:0] x_q, y_q, xs, ys;
  logic signed [Z_W-1:0]      z_q, z0, za;
  logic                       flip_q, flip0;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;

  function automatic logic signed [CORDIC_W-1:0] shr_tz(logic signed [CORDIC_W-1:0] v,
                                                        logic [4:0] s);
    logic [CORDIC_W-1:0] m;
    m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
    m = m >> s;
    return v[CORDIC_W-1] ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    z0    = {{(Z_W-32){angle_i[31]}}, angle_i};
    flip0 = 1'b0;
    if (z0 > Z_W'(64'sd1073741824)) begin
      z0    = z0 - Z_W'(64'sd2147483648);
      flip0 = 1'b1;
    end else if (z0 < -Z_W'(64'sd1073741824)) begin
      z0    = z0 + Z_W'(64'sd2147483648);
      flip0 = 1'b1;
    end
    xs = shr_tz(x_q, 5'(cnt_q));
    ys = shr_tz(y_q, 5'(cnt_q));
    za = $signed({{(Z_W-30){1'b0}}, ATAN_TAB[5'(cnt_q)]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= $signed(CORDIC_GAIN);
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - za;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + za;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ===== rtl/ddo_regs.sv =====
// ----------------------------------------------------------------------------
// ddo_regs
// APB register file: wheel radius at 0x0, turn gain at 0x8.
// ----------------------------------------------------------------------------
module ddo_regs import ddo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  output logic [RADIUS_W-1:0] radius_o,
  output logic [GAIN_W-1:0]   gain_o
);

  logic [RADIUS_W-1:0] radius_q;
  logic [GAIN_W-1:0]   gain_q;
  logic                wr;

  assign wr     = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      gain_q   <= GAIN_RST;
    end else if (wr) begin
      if (paddr[3]) gain_q <= pwdata[GAIN_W-1:0];
      else          radius_q <= pwdata[RADIUS_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2:0] != 3'd0) prdata = '0;
    else if (paddr[3])      prdata = {{(64-GAIN_W){1'b0}}, gain_q};
    else                    prdata = {{(64-RADIUS_W){1'b0}}, radius_q};
  end

  assign radius_o = radius_q;
  assign gain_o   = gain_q;

endmodule

// ===== rtl/diff_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Two-wheel dead-reckoning odometry with a shared serial arithmetic unit.
// ----------------------------------------------------------------------------
// Input beats carry absolute left/right wheel angles and elapsed microseconds;
// each accepted beat yields one output beat with pose, speeds and a rates
// valid flag. The APB port sets wheel radius and turn gain; the user must set
// them only while idle, which the block does not enforce. The first beat
// after reset only seeds the reference angles. For every later beat the
// serial multiply/divide unit retires one bit a cycle through nine operations
// (two 20-bit, one 36-bit, two 30-bit, 20-bit and 52-bit multiplies, and
// two 64-step divides); the 24-step CORDIC runs alongside. With zero elapsed
// time the last two multiplies and both divides are skipped. in_ready_o is high
// only when no beat is in work. The result sits in an output register, so a
// new input beat is taken while it waits; a stalled receiver holds the next
// result in the final step until the register frees. Reset clears pose,
// references and the seeded flag and restores the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core import ddo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] left_wheel_angle_i,
  input  logic signed [31:0] right_wheel_angle_i,
  input  logic [DT_W-1:0]    elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] lin_vel_o,
  output logic signed [31:0] yaw_rate_o,
  output logic               rates_valid_o
);

  logic [RADIUS_W-1:0] radius;
  logic [GAIN_W-1:0]   gain;

  ddo_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .radius_o(radius), .gain_o(gain)
  );

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   seeded_q;

  logic [31:0] left_ref_q, right_ref_q, x_q, y_q, th_q, lin_q, yaw_q;
  logic        valid_q;
  logic [32:0] sabs_q, dabs_q;
  logic        sneg_q, dneg_q;
  logic [DT_W-1:0] dt_q;
  logic [63:0] sum_q, dif_q, dth_q, lq_q;

  logic [31:0] ox_q, oy_q, oth_q, olin_q, oyaw_q;
  logic        ovalid_q, out_v_q;

  md_req_t      md_req;
  logic [63:0]  md_a, md_b;
  logic         md_done;
  logic [127:0] md_acc;

  logic                       cd_start, cd_done;
  logic signed [CORDIC_W-1:0] cd_cos, cd_sin;

  logic        accept, load_out;
  logic [32:0] dl, dr, s33, d33;
  logic [CORDIC_W-1:0] cmag, smag;
  logic        cneg, sn;

  ddo_muldiv u_md (
    .clk_i, .rst_ni, .req_i(md_req), .a_i(md_a), .b_i(md_b),
    .done_o(md_done), .acc_o(md_acc)
  );

  ddo_cordic u_cd (
    .clk_i, .rst_ni, .start_i(cd_start), .angle_i(th_q),
    .done_o(cd_done), .cos_o(cd_cos), .sin_o(cd_sin)
  );

  function automatic logic [31:0] sat32(logic neg, logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - m);
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic [31:0] acc_sat(logic [31:0] acc, logic neg, logic [39:0] m);
    logic signed [41:0] s;
    s = $signed({{10{acc[31]}}, acc}) + (neg ? -$signed({2'b00, m}) : $signed({2'b00, m}));
    if (s > 42'sd2147483647)  return 32'h7FFF_FFFF;
    if (s < -42'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign cd_start   = accept && seeded_q;
  assign load_out   = (state_q == S_DONE) && (!out_v_q || out_ready_i);

  assign dl  = {1'b0, 32'(left_wheel_angle_i - left_ref_q)};
  assign dr  = {1'b0, 32'(right_wheel_angle_i - right_ref_q)};
  assign s33 = {dl[31], dl[31:0]} + {dr[31], dr[31:0]};
  assign d33 = {dr[31], dr[31:0]} - {dl[31], dl[31:0]};

  assign cneg = cd_cos[CORDIC_W-1];
  assign sn   = cd_sin[CORDIC_W-1];
  assign cmag = cneg ? CORDIC_W'(-cd_cos) : CORDIC_W'(cd_cos);
  assign smag = sn ? CORDIC_W'(-cd_sin) : CORDIC_W'(cd_sin);

  always_comb begin
    state_d      = state_q;
    started_d    = started_q;
    md_req.start = 1'b0;
    md_req.op    = MD_MUL;
    md_req.nbits = MD_N_W'(RADIUS_W);
    md_a         = '0;
    md_b         = '0;
    unique case (state_q)
      S_SUM: begin md_a = 64'(sabs_q); md_b = 64'(radius); end
      S_DIF: begin md_a = 64'(dabs_q); md_b = 64'(radius); end
      S_TH:  begin md_a = dif_q; md_b = 64'(gain); md_req.nbits = MD_N_W'(GAIN_W); end
      S_X:   begin md_a = sum_q >> 17; md_b = 64'(cmag); md_req.nbits = MD_N_W'(CORDIC_W); end
      S_Y:   begin md_a = sum_q >> 17; md_b = 64'(smag); md_req.nbits = MD_N_W'(CORDIC_W); end
      S_LIN: begin md_a = sum_q; md_b = MICROS; md_req.nbits = MD_N_W'(MICROS_W); end
      S_LDIV, S_YDIV: begin
        md_a = lq_q; md_b = 64'(dt_q); md_req.op = MD_DIV;
      end
      S_YAW: begin md_a = dth_q; md_b = YAW_K; md_req.nbits = MD_N_W'(YAW_K_W); end
      default: ;
    endcase
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = seeded_q ? S_SUM : S_DONE;
        started_d = 1'b0;
      end
      S_DONE: if (load_out) state_d = S_IDLE;
      default: begin
        if (!started_q && (state_q != S_X || cd_done)) begin
          md_req.start = 1'b1;
          started_d    = 1'b1;
        end else if (started_q && md_done) begin
          started_d = 1'b0;
          unique case (state_q)
            S_SUM:  state_d = S_DIF;
            S_DIF:  state_d = S_TH;
            S_TH:   state_d = S_X;
            S_X:    state_d = S_Y;
            S_Y:    state_d = (dt_q == '0) ? S_DONE : S_LIN;
            S_LIN:  state_d = S_LDIV;
            S_LDIV: state_d = S_YAW;
            S_YAW:  state_d = S_YDIV;
            default: state_d = S_DONE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      seeded_q    <= 1'b0;
      left_ref_q  <= '0;
      right_ref_q <= '0;
      x_q         <= '0;
      y_q         <= '0;
      th_q        <= '0;
      out_v_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      if (accept) begin
        seeded_q    <= 1'b1;
        left_ref_q  <= left_wheel_angle_i;
        right_ref_q <= right_wheel_angle_i;
      end
      if (started_q && md_done) begin
        unique case (state_q)
          S_TH: th_q <= th_q + (dneg_q ? 32'(32'd0 - md_acc[FRAC_BITS+16 +: 32])
                                       : md_acc[FRAC_BITS+16 +: 32]);
          S_X:  x_q  <= acc_sat(x_q, sneg_q ^ cneg, md_acc[26 +: 40]);
          S_Y:  y_q  <= acc_sat(y_q, sneg_q ^ sn, md_acc[26 +: 40]);
          default: ;
        endcase
      end
      if (load_out)         out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sabs_q  <= s33[32] ? 33'(-s33) : s33;
      sneg_q  <= s33[32];
      dabs_q  <= d33[32] ? 33'(-d33) : d33;
      dneg_q  <= d33[32];
      dt_q    <= elapsed_us_i;
      lin_q   <= '0;
      yaw_q   <= '0;
      valid_q <= 1'b0;
    end
    if (started_q && md_done) begin
      unique case (state_q)
        S_SUM:  sum_q <= md_acc[63:0];
        S_DIF:  dif_q <= md_acc[63:0];
        S_TH:   dth_q <= md_acc[FRAC_BITS+16 +: 64];
        S_LIN:  lq_q  <= md_acc[17 +: 64];
        S_LDIV: begin
          lin_q <= sat32(sneg_q, md_acc[63:0]);
          lq_q  <= md_acc[(61-FRAC_BITS) +: 64];
        end
        S_YAW:  lq_q  <= md_acc[(61-FRAC_BITS) +: 64];
        S_YDIV: begin
          yaw_q   <= sat32(dneg_q, md_acc[63:0]);
          valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
    if (load_out) begin
      ox_q     <= x_q;
      oy_q     <= y_q;
      oth_q    <= th_q;
      olin_q   <= lin_q;
      oyaw_q   <= yaw_q;
      ovalid_q <= valid_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign pos_x_o       = ox_q;
  assign pos_y_o       = oy_q;
  assign heading_o     = oth_q;
  assign lin_vel_o     = olin_q;
  assign yaw_rate_o    = oyaw_q;
  assign rates_valid_o = ovalid_q;

endmodule

// ===== rtl/ddo_checker.sv =====
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry core, bound to the top level.
// ----------------------------------------------------------------------------
module ddo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pos_x_o,
  input logic [31:0] lin_vel_o,
  input logic [31:0] yaw_rate_o,
  input logic        rates_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o))
    else $error("output beat dropped or changed under stall");

  a_rates_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rates_valid_o |-> lin_vel_o == 32'd0 && yaw_rate_o == 32'd0)
    else $error("speeds nonzero while rates invalid");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a beat is in work");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind diff_drive_odometry_core ddo_checker u_ddo_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .pready(pready), .in_valid_i(in_valid_i),
  .in_ready_o(in_ready_o), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .pos_x_o(pos_x_o), .lin_vel_o(lin_vel_o), .yaw_rate_o(yaw_rate_o),
  .rates_valid_o(rates_valid_o)
);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for diff_drive_odometry_core. Wheel angle beats go in
// with random gaps and output stalls, and an in-bench odometry predictor
// (CORDIC pose update, saturating position and speeds) tracks the core
// through several radius/gain settings written over APB.
// ----------------------------------------------------------------------------
module tb;
  import ddo_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hdg;
    logic [31:0] lin;
    logic [31:0] yaw;
    logic        ok;
  } odom_t;

  typedef struct packed {
    logic [31:0]     la;
    logic [31:0]     ra;
    logic [DT_W-1:0] dt;
    logic            typed;
    odom_t           res;
  } row_t;

  localparam int  N_ROWS = 10;
  localparam int  LIMIT  = 4000000;
  localparam odom_t ZERO_POSE = '0;
  localparam odom_t REST_POSE = '{x: 0, y: 0, hdg: 0, lin: 0, yaw: 0, ok: 1'b1};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] left_wheel_angle_i = '0, right_wheel_angle_i = '0;
  logic [DT_W-1:0]    elapsed_us_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, heading_o, lin_vel_o, yaw_rate_o;
  logic               rates_valid_o;

  diff_drive_odometry_core i_dut (.*);

  // predictor state
  logic [RADIUS_W-1:0] radius_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [31:0]         lref_q, rref_q, xacc_q, yacc_q, thacc_q;
  bit                  seeded_q;

  odom_t pose_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    calm = 1'b0;
  int    stall_cnt = 0;

  function automatic longint trunc_shr(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s,
                                          output bit over);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> s;
    over = |p[127:64];
    return p[63:0];
  endfunction

  function automatic logic [31:0] clamp32(bit neg, logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic [31:0] acc_add(logic [31:0] acc, longint d);
    longint s;
    s = longint'($signed(acc)) + d;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic void sincos(logic [31:0] ang, output longint c, output longint sn);
    longint z, x, y, xs, ys;
    bit     flip;
    z = longint'($signed(ang));
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = trunc_shr(x, i);
      ys = trunc_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
      end
    end
    c  = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic odom_t odometry_step(logic [31:0] la, logic [31:0] ra,
                                          logic [DT_W-1:0] dt);
    odom_t  o;
    longint dl, dr, r, sum, diff, fwd, c, sn;
    logic [63:0] dth, q, mag;
    bit     over, o2, neg;
    o = '0;
    if (!seeded_q) begin
      lref_q = la; rref_q = ra; seeded_q = 1'b1;
    end else begin
      dl = longint'($signed(la - lref_q));
      dr = longint'($signed(ra - rref_q));
      r = longint'(radius_q);
      sum = dl * r + dr * r;
      diff = (dr - dl) * r;
      fwd = trunc_shr(sum, 17);
      neg = diff < 0;
      mag = neg ? -diff : diff;
      dth = mul_shr(mag, 64'(gain_q), FRAC_BITS + 16, over);
      lref_q = la; rref_q = ra;
      sincos(thacc_q, c, sn);
      xacc_q = acc_add(xacc_q, trunc_shr(fwd * c, 26));
      yacc_q = acc_add(yacc_q, trunc_shr(fwd * sn, 26));
      thacc_q = thacc_q + (neg ? 32'(-dth) : dth[31:0]);
      if (dt != 0) begin
        mag = (sum < 0) ? -sum : sum;
        q = mul_shr(mag, MICROS, 17, o2);
        o.lin = clamp32(sum < 0, o2 ? 64'hFFFF_FFFF_FFFF_FFFF : q / 64'(dt));
        if (over || dth[63]) dth = 64'h7FFF_FFFF_FFFF_FFFF;
        q = mul_shr(dth, YAW_K, 61 - FRAC_BITS, o2);
        o.yaw = clamp32(neg, o2 ? 64'hFFFF_FFFF_FFFF_FFFF : q / 64'(dt));
        o.ok = 1'b1;
      end
    end
    o.x = xacc_q; o.y = yacc_q; o.hdg = thacc_q;
    return o;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL diff_drive_odometry_core");
      $finish;
    end
  end

  // result side: check and stall
  always @(posedge clk_i) begin
    odom_t e;
    if (out_valid_o && out_ready_i) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (pos_x_o !== e.x) begin
          $error("pos_x exp %h got %h", e.x, pos_x_o); errors++;
        end
        if (pos_y_o !== e.y) begin
          $error("pos_y exp %h got %h", e.y, pos_y_o); errors++;
        end
        if (heading_o !== e.hdg) begin
          $error("heading exp %h got %h", e.hdg, heading_o); errors++;
        end
        if (lin_vel_o !== e.lin) begin
          $error("lin_vel exp %h got %h", e.lin, lin_vel_o); errors++;
        end
        if (yaw_rate_o !== e.yaw) begin
          $error("yaw_rate exp %h got %h", e.yaw, yaw_rate_o); errors++;
        end
        if (rates_valid_o !== e.ok) begin
          $error("rates_valid exp %b got %b", e.ok, rates_valid_o); errors++;
        end
      end
    end
    if (!rst_ni || calm) begin
      out_ready_i <= 1'b1;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(3) == 0) begin
      stall_cnt <= $urandom_range(6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic reg_write(int idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(8 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == 0) radius_q = val[RADIUS_W-1:0];
    else gain_q = val[GAIN_W-1:0];
  endtask

  task automatic drain();
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic send_beat(logic [31:0] la, logic [31:0] ra, logic [DT_W-1:0] dt,
                           bit typed, odom_t res);
    odom_t p;
    @(posedge clk_i);
    if (!calm && $urandom_range(2) == 0) begin
      repeat ($urandom_range(7, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_wheel_angle_i <= la;
    right_wheel_angle_i <= ra;
    elapsed_us_i <= dt;
    do @(posedge clk_i); while (!in_ready_o);
    p = odometry_step(la, ra, dt);
    pose_q.push_back(typed ? res : p);
    in_valid_i <= 1'b0;
  endtask

  task automatic random_beats(int n);
    logic [31:0]     la, ra;
    logic [DT_W-1:0] dt;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: begin
          la = $urandom; ra = $urandom; dt = DT_W'($urandom);
        end
        1: begin
          la = lref_q + ($urandom_range(4095) - 2048);
          ra = rref_q + ($urandom_range(4095) - 2048);
          dt = 0;
        end
        default: begin
          la = lref_q + ($urandom_range(32'h3FFFFF) - 32'h200000);
          ra = rref_q + ($urandom_range(32'h3FFFFF) - 32'h200000);
          dt = DT_W'($urandom_range(100000, 1));
        end
      endcase
      send_beat(la, ra, dt, 1'b0, ZERO_POSE);
    end
  endtask

  row_t rows [N_ROWS];

  initial begin
    rows[0] = '{32'h0000_0000, 32'h0000_0000, 24'd0,       1'b1, ZERO_POSE};
    rows[1] = '{32'h0000_0000, 32'h0000_0000, 24'd1000,    1'b1, REST_POSE};
    rows[2] = '{32'h0001_0000, 32'h0001_0000, 24'd1000,    1'b0, ZERO_POSE};
    rows[3] = '{32'h8000_0000, 32'h7FFF_FFFF, 24'd0,       1'b0, ZERO_POSE};
    rows[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 24'hFFFFFF,  1'b0, ZERO_POSE};
    rows[5] = '{32'h0000_0000, 32'h0040_0000, 24'd1,       1'b0, ZERO_POSE};
    rows[6] = '{32'h0000_0000, 32'hFFFF_FFFF, 24'd50000,   1'b0, ZERO_POSE};
    rows[7] = '{32'h1234_5678, 32'h8765_4321, 24'd20000,   1'b0, ZERO_POSE};
    rows[8] = '{32'h1235_5678, 32'h8764_4321, 24'd1,       1'b0, ZERO_POSE};
    rows[9] = '{32'h1235_5678, 32'h8764_4321, 24'd1,       1'b1,
                '{x: 0, y: 0, hdg: 0, lin: 0, yaw: 0, ok: 1'b1}};

    radius_q = RADIUS_RST; gain_q = GAIN_RST;
    lref_q = '0; rref_q = '0; xacc_q = '0; yacc_q = '0; thacc_q = '0;
    seeded_q = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed && i > 1) begin
        rows[i].res.x = xacc_q; rows[i].res.y = yacc_q; rows[i].res.hdg = thacc_q;
      end
      send_beat(rows[i].la, rows[i].ra, rows[i].dt, rows[i].typed, rows[i].res);
    end
    random_beats(120);

    drain();
    reg_write(0, 64'hF_FFFF);
    reg_write(1, 64'hF_FFFF_FFFF);
    send_beat(32'h0000_0000, 32'h7FFF_0000, 24'd1, 1'b0, ZERO_POSE);
    send_beat(32'h8000_0000, 32'h0000_0000, 24'd1, 1'b0, ZERO_POSE);
    random_beats(120);

    drain();
    reg_write(0, 64'd1);
    reg_write(1, 64'd1);
    random_beats(100);

    drain();
    reg_write(0, 64'd0);
    reg_write(1, 64'd0);
    random_beats(60);

    drain();
    reg_write(0, 64'($urandom_range(32'hFFFFF, 1)));
    reg_write(1, {$urandom_range(15), 32'($urandom)});
    random_beats(150);
    while (pose_q.size() != 0) @(posedge clk_i);
    random_beats(150);

    drain();
    reg_write(0, 64'(RADIUS_RST));
    reg_write(1, 64'(GAIN_RST));
    random_beats(100);
    calm = 1'b1;
    random_beats(100);

    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS diff_drive_odometry_core");
    end else begin
      $display("FAIL diff_drive_odometry_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ddo_pkg.sv
rtl/ddo_muldiv.sv
rtl/ddo_cordic.sv
rtl/ddo_regs.sv
rtl/diff_drive_odometry_core.sv
rtl/ddo_checker.sv
tb/tb.sv
